// ===== hdl/sst_pkg.sv =====
package sst_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INSERTED      = 3'd0,
		ST_DUPLICATE     = 3'd1,
		ST_REMOVED       = 3'd2,
		ST_REMOVE_ABSENT = 3'd3,
		ST_FOUND         = 3'd4,
		ST_NOT_FOUND     = 3'd5,
		ST_FULL          = 3'd6
	} status_t;

	// Shift commands broadcast to every cell of the row.
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

// ===== hdl/sst_req_if.sv =====
interface sst_req_if #(
	parameter int VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   opcode;
	logic signed [VALUE_BITS-1:0] item_value;

	modport source (output valid, output opcode, output item_value, input ready);
	modport sink (input valid, input opcode, input item_value, output ready);
endinterface

// ===== hdl/sst_rsp_if.sv =====
interface sst_rsp_if import sst_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 5
);
	logic                         valid;
	logic                         ready;
	status_t                      status;
	logic signed [VALUE_BITS-1:0] echo_value;
	logic [COUNT_BITS-1:0]        entry_total;

	modport source (output valid, output status, output echo_value, output entry_total,
		input ready);
	modport sink (input valid, input status, input echo_value, input entry_total,
		output ready);
endinterface

// ===== hdl/sst_cell.sv =====
module sst_cell import sst_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctrl_t                   ctrl,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic signed [VALUE_BITS-1:0] left_entry,
	input  logic                         left_valid,
	input  logic                         left_lt,
	input  logic signed [VALUE_BITS-1:0] right_entry,
	input  logic                         right_valid,
	output logic signed [VALUE_BITS-1:0] entry_q,
	output logic                         valid_q,
	output logic                         lt,
	output logic                         eq
);

	assign lt = valid_q && (entry_q < value);
	assign eq = valid_q && (entry_q == value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!lt) begin
			if (ctrl.insert) begin
				valid_q <= left_valid;
			end else if (ctrl.remove) begin
				valid_q <= right_valid;
			end
		end
	end

	// An insert opens a gap at the first entry not below the value and pushes
	// the rest one cell to the right; a remove pulls them one cell to the left.
	always_ff @(posedge clk) begin
		if (!lt) begin
			if (ctrl.insert) begin
				entry_q <= left_lt ? value : left_entry;
			end else if (ctrl.remove) begin
				entry_q <= right_entry;
			end
		end
	end

endmodule

// ===== hdl/sorted_set_table.sv =====
// Sorted set table: keeps up to CAPACITY distinct signed values in ascending
// order in a row of cells, each holding one entry and its occupied flag.
//
// Channels: req carries an opcode (insert, remove, search) and a value; rsp
// returns one item per request with a status, the value it carried and the
// number of stored entries after the operation. Opcode 3 acts as a search.
//
// Every cell compares its entry with the request value at once, and an insert
// or remove shifts the row by one cell in the same cycle, so the block takes
// one item per cycle unless the receiver stalls; the response appears in the
// cycle after acceptance. The compare across the whole row sets that rate.
//
// The response sits in an output register. While the receiver stalls, that
// register holds and req.ready is low; no item is lost or repeated.
//
// Reset empties the table and clears the response valid flag; req.ready stays
// low until the first clock edge after reset is released.
module sorted_set_table import sst_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input logic      clk,
	input logic      arst_n,
	sst_req_if.sink  req,
	sst_rsp_if.source rsp
);

	localparam int COUNT_BITS = $clog2(CAPACITY + 1);

	logic signed [VALUE_BITS-1:0] entry [CAPACITY];
	logic [CAPACITY-1:0]          occ;
	logic [CAPACITY-1:0]          lt;
	logic [CAPACITY-1:0]          eq;

	logic                  run_q;
	logic                  accept;
	logic                  found;
	logic                  full;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_d;
	status_t               status_d;
	cell_ctrl_t            ctrl;

	logic                         rsp_valid_q;
	status_t                      status_q;
	logic signed [VALUE_BITS-1:0] echo_q;
	logic [COUNT_BITS-1:0]        total_q;

	assign req.ready = run_q && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign found     = |eq;
	assign full      = occ[CAPACITY-1];

	always_comb begin
		ctrl     = '0;
		count_d  = count_q;
		status_d = ST_NOT_FOUND;
		case (opcode_t'(req.opcode))
			OP_INSERT: begin
				if (found) begin
					status_d = ST_DUPLICATE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d    = ST_INSERTED;
					ctrl.insert = accept;
					count_d     = count_q + COUNT_BITS'(1);
				end
			end
			OP_REMOVE: begin
				if (found) begin
					status_d    = ST_REMOVED;
					ctrl.remove = accept;
					count_d     = count_q - COUNT_BITS'(1);
				end else begin
					status_d = ST_REMOVE_ABSENT;
				end
			end
			default: begin
				status_d = found ? ST_FOUND : ST_NOT_FOUND;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_BITS-1:0] left_entry;
		logic signed [VALUE_BITS-1:0] right_entry;
		logic                         left_valid;
		logic                         left_lt;
		logic                         right_valid;

		if (i == 0) begin : g_first
			assign left_entry = '0;
			assign left_valid = 1'b1;
			assign left_lt    = 1'b1;
		end else begin : g_inner_left
			assign left_entry = entry[i-1];
			assign left_valid = occ[i-1];
			assign left_lt    = lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner_right
			assign right_entry = entry[i+1];
			assign right_valid = occ[i+1];
		end

		sst_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.value      (req.item_value),
			.left_entry (left_entry),
			.left_valid (left_valid),
			.left_lt    (left_lt),
			.right_entry(right_entry),
			.right_valid(right_valid),
			.entry_q    (entry[i]),
			.valid_q    (occ[i]),
			.lt         (lt[i]),
			.eq         (eq[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			echo_q   <= req.item_value;
			total_q  <= count_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.echo_value  = echo_q;
	assign rsp.entry_total = total_q;

endmodule

// ===== hdl/sst_checker.sv =====
module sst_checker import sst_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 5
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic signed [VALUE_BITS-1:0] req_item_value,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input status_t                      rsp_status,
	input logic signed [VALUE_BITS-1:0] rsp_echo_value,
	input logic [COUNT_BITS-1:0]        rsp_entry_total
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_value)
			&& $stable(rsp_status) && $stable(rsp_entry_total))
		else $error("Stalled response item changed.");

	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid && rsp_echo_value == $past(req_item_value))
		else $error("Response item did not follow its request.");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("Request taken while the response item was stalled.");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_entry_total <= COUNT_BITS'(CAPACITY))
		else $error("Entry count exceeds the capacity.");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_entry_total == COUNT_BITS'(CAPACITY))
		else $error("Full reported with free entries left.");

endmodule

bind sorted_set_table sst_checker #(
	.CAPACITY  (CAPACITY),
	.VALUE_BITS(VALUE_BITS),
	.COUNT_BITS(COUNT_BITS)
) u_sst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_item_value (req.item_value),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_echo_value (rsp.echo_value),
	.rsp_entry_total(rsp.entry_total)
);
